@@ hw/rtl/mdds_pkg.sv @@
// Shared types and constants for the multiplexed digit display scanner.
package mdds_pkg;

  localparam int CODE_SLOTS  = 5;
  localparam int GLYPH_COUNT = 25;
  localparam int CODE_W      = 8;
  localparam int DIGIT_W     = 5;
  localparam int SEG_W       = 9;
  localparam int PULSE_W     = 16;

  localparam logic [SEG_W-1:0]   SEG_PORT_MASK = 9'h1FE;
  localparam logic [SEG_W-1:0]   DOT_BIT       = 9'h100;
  localparam logic [PULSE_W-1:0] PULSE_RESET   = 16'd2000;

  localparam logic ACTION_FRAME = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [PULSE_W-1:0] pulse_t;

  typedef code_t [CODE_SLOTS-1:0] frame_t;

  typedef struct packed {
    digit_t digit_enable;
    seg_t   segment_bits;
    logic   motor_on;
  } mdds_result_t;

  localparam seg_t GLYPH_ROM [GLYPH_COUNT] = '{
    9'h07E, 9'h00C, 9'h0B6, 9'h09E, 9'h0CC, 9'h0DA, 9'h0FA, 9'h00E, 9'h0FE, 9'h0DE,
    9'h07E | DOT_BIT, 9'h00C | DOT_BIT, 9'h0B6 | DOT_BIT, 9'h09E | DOT_BIT,
    9'h0CC | DOT_BIT, 9'h0DA | DOT_BIT, 9'h0FA | DOT_BIT, 9'h00E | DOT_BIT,
    9'h0FE | DOT_BIT, 9'h0DE | DOT_BIT,
    9'h0A8, 9'h0F2, 9'h0B8, 9'h080, 9'h000
  };

endpackage

@@ hw/rtl/mdds_if.sv @@
// Request and result channel interfaces for the display scanner.
interface mdds_in_if;
  import mdds_pkg::*;
  logic  valid;
  logic  ready;
  logic  action;
  code_t code_first;
  code_t code_second;
  code_t code_third;
  code_t code_fourth;
  code_t code_fifth;

  modport source (output valid, action, code_first, code_second, code_third,
                  code_fourth, code_fifth, input ready);
  modport sink (input valid, action, code_first, code_second, code_third,
                code_fourth, code_fifth, output ready);
endinterface

interface mdds_out_if;
  import mdds_pkg::*;
  logic   valid;
  logic   ready;
  digit_t digit_enable;
  seg_t   segment_bits;
  logic   motor_on;

  modport source (output valid, digit_enable, segment_bits, motor_on, input ready);
  modport sink (input valid, digit_enable, segment_bits, motor_on, output ready);
endinterface

@@ hw/rtl/mdds_glyph_dec.sv @@
// Glyph code to segment pattern decoder.
module mdds_glyph_dec (
  input  mdds_pkg::code_t code,
  output mdds_pkg::seg_t  segs
);
  import mdds_pkg::*;

  logic [4:0] idx;

  assign idx  = code[4:0];
  assign segs = (code < CODE_W'(GLYPH_COUNT)) ? (GLYPH_ROM[idx] & SEG_PORT_MASK) : '0;

endmodule

@@ hw/rtl/mdds_core.sv @@
// Scanner state: stored codes, scan position, motor pulse and shown digit.
module mdds_core #(
  parameter int DIGIT_COUNT = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  mdds_pkg::pulse_t       cfg_wdata,
  input  logic                   accept,
  input  logic                   action,
  input  mdds_pkg::frame_t       frame,
  output mdds_pkg::mdds_result_t result
);
  import mdds_pkg::*;

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  pulse_t           pulse_ticks_r;
  frame_t           codes_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  code_t            last_first_r;
  pulse_t           remain_r, remain_nxt;
  digit_t           shown_digit_r, shown_digit_nxt;
  seg_t             shown_seg_r, shown_seg_nxt;

  logic [3:0] pos_ext;
  logic [4:0] pos_inc;
  logic [2:0] sel;
  logic       in_range;
  code_t      cur_code;
  seg_t       dec_segs;
  logic       motor;

  assign pos_ext  = 4'(pos_r);
  assign pos_inc  = 5'(pos_ext) + 5'd1;
  assign sel      = pos_ext[2:0];
  assign in_range = pos_ext < 4'(CODE_SLOTS);
  assign cur_code = in_range ? codes_r[sel] : '0;

  mdds_glyph_dec u_dec (
    .code (cur_code),
    .segs (dec_segs)
  );

  always_comb begin
    pos_nxt         = pos_r;
    remain_nxt      = remain_r;
    shown_digit_nxt = shown_digit_r;
    shown_seg_nxt   = shown_seg_r;
    motor           = remain_r != '0;
    if (action == ACTION_FRAME) begin
      if (frame[0] != last_first_r && remain_r == '0) begin
        remain_nxt = pulse_ticks_r;
      end
      motor = remain_nxt != '0;
    end else begin
      shown_digit_nxt = in_range ? DIGIT_W'(5'd1 << sel) : '0;
      shown_seg_nxt   = in_range ? dec_segs : '0;
      pos_nxt         = (pos_inc >= 5'(DIGIT_COUNT)) ? '0 : POS_W'(pos_inc);
      if (remain_r != '0) begin
        remain_nxt = remain_r - 1'b1;
      end
    end
  end

  assign result = '{digit_enable: shown_digit_nxt, segment_bits: shown_seg_nxt,
                    motor_on: motor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_RESET;
      codes_r       <= '0;
      pos_r         <= '0;
      last_first_r  <= '0;
      remain_r      <= '0;
      shown_digit_r <= '0;
      shown_seg_r   <= '0;
    end else begin
      if (cfg_we) begin
        pulse_ticks_r <= cfg_wdata;
      end
      if (accept) begin
        pos_r         <= pos_nxt;
        remain_r      <= remain_nxt;
        shown_digit_r <= shown_digit_nxt;
        shown_seg_r   <= shown_seg_nxt;
        if (action == ACTION_FRAME) begin
          codes_r      <= frame;
          last_first_r <= frame[0];
        end
      end
    end
  end

endmodule

@@ hw/rtl/mdds_out_stage.sv @@
// Result register between the scanner state and the result channel.
module mdds_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  mdds_pkg::mdds_result_t result,
  output logic                   can_load,
  mdds_out_if.source             out_chan
);
  import mdds_pkg::*;

  logic         valid_r;
  mdds_result_t data_r;

  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.digit_enable = data_r.digit_enable;
  assign out_chan.segment_bits = data_r.segment_bits;
  assign out_chan.motor_on     = data_r.motor_on;

endmodule

@@ hw/rtl/multiplexed_digit_display_scanner_top.sv @@
// Top level of the multiplexed digit display scanner.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   action, code_first .. code_fifth
//   out_chan  out  valid/ready   digit_enable, segment_bits, motor_on
//   cfg_*     in   write enable  pulse_ticks (16 bit)
//
// One request per cycle; each result is registered and shows on out_chan in the cycle after its request.
// The result register limits the rate: a request is taken when it is empty
// or being drained in the same cycle.
// Synchronous active-low reset clears state; pulse length resets to 2000.
// A stall on out_chan holds the result and stops new requests.
module multiplexed_digit_display_scanner_top #(
  parameter int DIGIT_COUNT = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  mdds_pkg::pulse_t cfg_wdata,
  mdds_in_if.sink          in_chan,
  mdds_out_if.source       out_chan
);
  import mdds_pkg::*;

  logic         can_load;
  logic         accept;
  frame_t       frame;
  mdds_result_t result;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  assign frame[0] = in_chan.code_first;
  assign frame[1] = in_chan.code_second;
  assign frame[2] = in_chan.code_third;
  assign frame[3] = in_chan.code_fourth;
  assign frame[4] = in_chan.code_fifth;

  mdds_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .action    (in_chan.action),
    .frame     (frame),
    .result    (result)
  );

  mdds_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

@@ sim/mdds_tb_pkg.sv @@
// Display scanner prediction and output checking for the scanner testbench.
package mdds_tb_pkg;
  import mdds_pkg::*;

  typedef struct packed {
    logic   action;
    frame_t codes;
  } scan_request_t;

  class scan_model;
    int unsigned  digit_count;
    pulse_t       pulse_len;
    frame_t       codes;
    int unsigned  scan_pos;
    code_t        last_lead;
    pulse_t       pulse_left;
    digit_t       lit_digit;
    seg_t         lit_segs;
    mdds_result_t pending_outputs[$];
    int unsigned  mismatches;

    function new(int unsigned count);
      digit_count = count;
      pulse_len   = 16'd2000;
      codes       = '0;
      scan_pos    = 0;
      last_lead   = '0;
      pulse_left  = '0;
      lit_digit   = '0;
      lit_segs    = '0;
      mismatches  = 0;
    endfunction

    function seg_t glyph_segments(code_t code);
      seg_t base;
      if (code >= GLYPH_COUNT) return '0;
      if (code >= 8'd20) begin
        case (code)
          8'd20:   return 9'h0A8;
          8'd21:   return 9'h0F2;
          8'd22:   return 9'h0B8;
          8'd23:   return 9'h080;
          default: return 9'h000;
        endcase
      end
      case (code % 10)
        0:       base = 9'h07E;
        1:       base = 9'h00C;
        2:       base = 9'h0B6;
        3:       base = 9'h09E;
        4:       base = 9'h0CC;
        5:       base = 9'h0DA;
        6:       base = 9'h0FA;
        7:       base = 9'h00E;
        8:       base = 9'h0FE;
        default: base = 9'h0DE;
      endcase
      if (code >= 8'd10) base = base | 9'h100;
      return base;
    endfunction

    function void note_request(scan_request_t req);
      mdds_result_t res;
      logic         motor;
      if (req.action == ACTION_FRAME) begin
        codes = req.codes;
        if (codes[0] != last_lead && pulse_left == '0) pulse_left = pulse_len;
        last_lead = codes[0];
        motor = (pulse_left != '0);
      end else begin
        if (scan_pos < CODE_SLOTS) begin
          lit_digit = digit_t'(1 << scan_pos);
          lit_segs  = glyph_segments(codes[scan_pos]);
        end else begin
          lit_digit = '0;
          lit_segs  = '0;
        end
        scan_pos = (scan_pos + 1 >= digit_count) ? 0 : scan_pos + 1;
        motor = (pulse_left != '0);
        if (motor) pulse_left = pulse_left - 1'b1;
      end
      res.digit_enable = lit_digit;
      res.segment_bits = lit_segs;
      res.motor_on     = motor;
      pending_outputs.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_output(digit_t digit, seg_t segs, logic motor);
      mdds_result_t want;
      if (pending_outputs.size() == 0) begin
        flag($sformatf("unexpected output digit_enable=%h segment_bits=%h motor_on=%b",
                       digit, segs, motor));
        return;
      end
      want = pending_outputs.pop_front();
      if (digit !== want.digit_enable)
        flag($sformatf("digit_enable expected %h got %h", want.digit_enable, digit));
      if (segs !== want.segment_bits)
        flag($sformatf("segment_bits expected %h got %h", want.segment_bits, segs));
      if (motor !== want.motor_on)
        flag($sformatf("motor_on expected %b got %b", want.motor_on, motor));
    endfunction
  endclass

endpackage

@@ sim/tb_multiplexed_digit_display_scanner_top.sv @@
// Testbench top for the multiplexed digit display scanner.
module tb_multiplexed_digit_display_scanner_top;
  import mdds_pkg::*;
  import mdds_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIGIT_COUNT = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 125;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  pulse_t      cfg_wdata;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int unsigned cycle_count;
  scan_model   model;

  mdds_in_if  in_chan ();
  mdds_out_if out_chan ();

  multiplexed_digit_display_scanner_top #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** multiplexed_digit_display_scanner_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      model.check_output(out_chan.digit_enable, out_chan.segment_bits, out_chan.motor_on);
    out_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  function automatic code_t random_code();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return code_t'($urandom_range(0, GLYPH_COUNT - 1));
    if (pick < 9) return code_t'($urandom_range(GLYPH_COUNT, 255));
    return code_t'($urandom);
  endfunction

  function automatic scan_request_t random_request();
    scan_request_t req;
    req.action = ($urandom_range(0, 99) < 70) ? ACTION_TICK : ACTION_FRAME;
    for (int i = 0; i < CODE_SLOTS; i++) req.codes[i] = random_code();
    // repeat lead codes often so the pulse start sees both outcomes
    if ($urandom_range(0, 1) == 1) req.codes[0] = code_t'($urandom_range(0, 2));
    return req;
  endfunction

  function automatic scan_request_t tick_request();
    scan_request_t req;
    req = random_request();
    req.action = ACTION_TICK;
    return req;
  endfunction

  function automatic scan_request_t frame_request(code_t c0, code_t c1, code_t c2,
                                                  code_t c3, code_t c4);
    scan_request_t req;
    req.action = ACTION_FRAME;
    req.codes  = {c4, c3, c2, c1, c0};
    return req;
  endfunction

  task automatic send_request(scan_request_t req);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= req.action;
    in_chan.code_first  <= req.codes[0];
    in_chan.code_second <= req.codes[1];
    in_chan.code_third  <= req.codes[2];
    in_chan.code_fourth <= req.codes[3];
    in_chan.code_fifth  <= req.codes[4];
    do @(posedge clk); while (!in_chan.ready);
    model.note_request(req);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (model.pending_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_pulse_len(pulse_t len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.pulse_len = len;
  endtask

  initial begin
    pulse_t phase_pulse [PHASES];
    model = new(DIGIT_COUNT);
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= ACTION_FRAME;
    in_chan.code_first  <= '0;
    in_chan.code_second <= '0;
    in_chan.code_third  <= '0;
    in_chan.code_fourth <= '0;
    in_chan.code_fifth  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // frame before first tick, glyph sweep, pulse start and hold, blank codes
    send_request(frame_request(8'd0, 8'd1, 8'd2, 8'd3, 8'd4));
    repeat (5) send_request(tick_request());
    send_request(frame_request(8'd9, 8'd19, 8'd20, 8'd21, 8'd22));
    repeat (5) send_request(tick_request());
    send_request(frame_request(8'd23, 8'd24, 8'd25, 8'd255, 8'd10));
    repeat (5) send_request(tick_request());
    send_request(frame_request(8'd23, 8'd128, 8'd127, 8'd11, 8'd18));
    send_request(tick_request());

    phase_pulse = '{16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd0, 16'd0};
    phase_pulse[4] = pulse_t'($urandom_range(2, 40));
    phase_pulse[5] = pulse_t'($urandom_range(1, 300));
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 49;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 49;
        end
        default: begin
          sender_idle_pct    = 19;
          receiver_stall_pct = 19;
        end
      endcase
      write_pulse_len(phase_pulse[phase]);
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    in_chan.valid <= 1'b0;
    while (model.pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (model.mismatches == 0 && model.pending_outputs.size() == 0)
      $display("** multiplexed_digit_display_scanner_top: PASSED **");
    else
      $display("** multiplexed_digit_display_scanner_top: FAILED **");
    $finish;
  end

endmodule

@@ multiplexed_digit_display_scanner_top.f @@
hw/rtl/mdds_pkg.sv
hw/rtl/mdds_if.sv
hw/rtl/mdds_glyph_dec.sv
hw/rtl/mdds_core.sv
hw/rtl/mdds_out_stage.sv
hw/rtl/multiplexed_digit_display_scanner_top.sv
sim/mdds_tb_pkg.sv
sim/tb_multiplexed_digit_display_scanner_top.sv
